>>> rtl/bmp_pkg.sv
package bmp_pkg;

	// Field widths of a request and a result.
	localparam int IN_W  = 17;
	localparam int VAL_W = 30;

	// Factorial table size.
	localparam int MAX_N  = 131071;
	localparam int DEPTH  = MAX_N + 1;
	localparam int IDX_W  = $clog2(DEPTH);

	// Prime modulus and the Fermat exponent p - 2.
	localparam logic [31:0]      MOD_P   = 32'd1000000007;
	localparam logic [31:0]      MOD_P2  = 32'd2000000014;
	localparam logic [31:0]      MOD_P3  = 32'd3000000021;
	localparam logic [VAL_W-1:0] EXP_INV = 30'd1000000005;
	localparam int               EXP_W   = VAL_W;

	// Barrett reciprocal floor(2^61 / p) for the modular multiplier.
	localparam logic [31:0] BARRETT_M = 32'((64'd1 << 61) / 64'd1000000007);

	// Latency of the modular multiplier in cycles.
	localparam int MM_LAT = 5;

	// Queue between front and back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef struct packed {
		logic [IN_W-1:0] n_value;
		logic [IN_W-1:0] k_value;
	} query_t;

	typedef struct packed {
		logic [VAL_W-1:0] binom_value;
		logic             invalid;
	} result_t;

	// Classified request as it waits in the queue.
	typedef struct packed {
		logic [IDX_W-1:0] n_addr;
		logic [IDX_W-1:0] k_addr;
		logic [IDX_W-1:0] d_addr;
		logic             bad;
		logic             one;
	} qent_t;

	// Modular multiply request and response.
	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] a;
		logic [VAL_W-1:0] b;
	} mm_req_t;

	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] y;
	} mm_rsp_t;

	// Table write from the start-up fill.
	typedef struct packed {
		logic             fact_we;
		logic             inv_we;
		logic [IDX_W-1:0] addr;
		logic [VAL_W-1:0] data;
	} tbl_wr_t;

	typedef enum logic [2:0] {
		INIT_ZERO,
		INIT_FACT,
		INIT_POW_ACC,
		INIT_POW_SQ,
		INIT_TOP,
		INIT_INV,
		INIT_DONE
	} init_state_t;

endpackage

>>> rtl/bmp_if.sv
interface bmp_query_if import bmp_pkg::*; ();
	logic   valid;
	logic   ready;
	query_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface bmp_result_if import bmp_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> rtl/binomial_mod_prime_top.sv
// Path from an accepted request to its result: queue, table read, two five-stage
// modular multipliers, output register; all of it holds while the output stalls.
// Throughput: one request per cycle unless stalled, set by the fully pipelined multipliers.
// Reset: asynchronous, active low; afterwards the factorial and inverse-factorial
// tables are filled, and no request is accepted until the fill is done.
module binomial_mod_prime_top import bmp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	bmp_query_if.sink    query,
	bmp_result_if.source result
);

	mm_req_t init_req;
	mm_rsp_t init_rsp;
	tbl_wr_t tbl_wr;
	logic    init_busy;
	qent_t   head;
	logic    head_valid;
	logic    pop;

	// Start-up table fill.
	bmp_init u_init (
		.clk(clk), .arst_n(arst_n), .mm_rsp(init_rsp), .mm_req(init_req),
		.tbl_wr(tbl_wr), .busy(init_busy)
	);

	// Request intake and classification.
	bmp_front u_front (
		.clk(clk), .arst_n(arst_n), .init_busy(init_busy), .query(query),
		.pop(pop), .head(head), .head_valid(head_valid)
	);

	// Table lookups and modular products.
	bmp_back u_back (
		.clk(clk), .arst_n(arst_n), .init_busy(init_busy), .init_req(init_req),
		.init_rsp(init_rsp), .tbl_wr(tbl_wr), .head(head), .head_valid(head_valid),
		.pop(pop), .result(result)
	);

endmodule

>>> rtl/bmp_ram.sv
module bmp_ram #(
	parameter int W = 30,
	parameter int D = 2
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/bmp_modmul.sv
module bmp_modmul import bmp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  mm_req_t req,
	output mm_rsp_t rsp
);

	logic [59:0]      x_s1;
	logic [30:0]      q_s2;
	logic [31:0]      xl_s2;
	logic [31:0]      qp_s3;
	logic [31:0]      xl_s3;
	logic [31:0]      r_s4;
	logic [VAL_W-1:0] y_s5;
	logic [MM_LAT-1:0] v_q;
	logic [62:0]      qprod;
	logic [60:0]      pprod;
	logic [31:0]      r_fix;

	// Barrett quotient estimate and its multiple of p.
	assign qprod = 63'(x_s1[59:29]) * 63'(BARRETT_M);
	assign pprod = 61'(q_s2) * 61'(MOD_P);

	// The estimate is low by at most three, so the remainder is below 4p.
	always_comb begin
		priority if (r_s4 >= MOD_P3) begin
			r_fix = r_s4 - MOD_P3;
		end else if (r_s4 >= MOD_P2) begin
			r_fix = r_s4 - MOD_P2;
		end else if (r_s4 >= MOD_P) begin
			r_fix = r_s4 - MOD_P;
		end else begin
			r_fix = r_s4;
		end
	end

	// Datapath stages.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= 60'(req.a) * 60'(req.b);
			q_s2  <= qprod[62:32];
			xl_s2 <= x_s1[31:0];
			qp_s3 <= pprod[31:0];
			xl_s3 <= xl_s2;
			r_s4  <= xl_s3 - qp_s3;
			y_s5  <= r_fix[VAL_W-1:0];
		end
	end

	// Valid bits follow the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[MM_LAT-2:0], req.valid};
		end
	end

	assign rsp.valid = v_q[MM_LAT-1];
	assign rsp.y     = y_s5;

endmodule

>>> rtl/bmp_init.sv
module bmp_init import bmp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  mm_rsp_t mm_rsp,
	output mm_req_t mm_req,
	output tbl_wr_t tbl_wr,
	output logic    busy
);

	init_state_t      state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [VAL_W-1:0] cur_q, cur_d;
	logic [VAL_W-1:0] sq_q, sq_d;
	logic [4:0]       bit_q, bit_d;
	logic             pend_q, pend_d;

	// State and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= INIT_ZERO;
			idx_q   <= IDX_W'(1);
			cur_q   <= VAL_W'(1);
			sq_q    <= '0;
			bit_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			cur_q   <= cur_d;
			sq_q    <= sq_d;
			bit_q   <= bit_d;
			pend_q  <= pend_d;
		end
	end

	// Fill sequence: factorials upward, one Fermat inversion of MAX_N!,
	// then inverse factorials downward.
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cur_d   = cur_q;
		sq_d    = sq_q;
		bit_d   = bit_q;
		pend_d  = pend_q;
		mm_req.valid   = 1'b0;
		mm_req.a       = cur_q;
		mm_req.b       = VAL_W'(idx_q);
		tbl_wr.fact_we = 1'b0;
		tbl_wr.inv_we  = 1'b0;
		tbl_wr.addr    = idx_q;
		tbl_wr.data    = mm_rsp.y;
		busy           = 1'b1;
		unique case (state_q)
			INIT_ZERO: begin
				tbl_wr.fact_we = 1'b1;
				tbl_wr.addr    = '0;
				tbl_wr.data    = VAL_W'(1);
				state_d        = INIT_FACT;
			end
			INIT_FACT: begin
				if (!pend_q) begin
					mm_req.valid = 1'b1;
					pend_d       = 1'b1;
				end else if (mm_rsp.valid) begin
					tbl_wr.fact_we = 1'b1;
					cur_d          = mm_rsp.y;
					pend_d         = 1'b0;
					if (idx_q == IDX_W'(MAX_N)) begin
						sq_d    = mm_rsp.y;
						cur_d   = VAL_W'(1);
						bit_d   = '0;
						state_d = INIT_POW_ACC;
					end else begin
						idx_d = idx_q + IDX_W'(1);
					end
				end
			end
			INIT_POW_ACC: begin
				mm_req.b = sq_q;
				if (!EXP_INV[bit_q]) begin
					state_d = INIT_POW_SQ;
				end else if (!pend_q) begin
					mm_req.valid = 1'b1;
					pend_d       = 1'b1;
				end else if (mm_rsp.valid) begin
					cur_d   = mm_rsp.y;
					pend_d  = 1'b0;
					state_d = INIT_POW_SQ;
				end
			end
			INIT_POW_SQ: begin
				mm_req.a = sq_q;
				mm_req.b = sq_q;
				if (bit_q == 5'(EXP_W - 1)) begin
					state_d = INIT_TOP;
				end else if (!pend_q) begin
					mm_req.valid = 1'b1;
					pend_d       = 1'b1;
				end else if (mm_rsp.valid) begin
					sq_d    = mm_rsp.y;
					bit_d   = bit_q + 5'd1;
					pend_d  = 1'b0;
					state_d = INIT_POW_ACC;
				end
			end
			INIT_TOP: begin
				tbl_wr.inv_we = 1'b1;
				tbl_wr.addr   = IDX_W'(MAX_N);
				tbl_wr.data   = cur_q;
				idx_d         = IDX_W'(MAX_N);
				state_d       = INIT_INV;
			end
			INIT_INV: begin
				tbl_wr.addr = idx_q - IDX_W'(1);
				if (!pend_q) begin
					mm_req.valid = 1'b1;
					pend_d       = 1'b1;
				end else if (mm_rsp.valid) begin
					tbl_wr.inv_we = 1'b1;
					cur_d         = mm_rsp.y;
					pend_d        = 1'b0;
					if (idx_q == IDX_W'(1)) begin
						state_d = INIT_DONE;
					end else begin
						idx_d = idx_q - IDX_W'(1);
					end
				end
			end
			INIT_DONE: begin
				busy = 1'b0;
			end
			default: begin
				state_d = INIT_DONE;
			end
		endcase
	end

endmodule

>>> rtl/bmp_front.sv
module bmp_front import bmp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        init_busy,
	bmp_query_if.sink   query,
	input  logic        pop,
	output qent_t       head,
	output logic        head_valid
);

	qent_t             ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              push;
	logic              do_pop;
	qent_t             cls;

	// Classify the request: rejected, trivially one, or a full product.
	always_comb begin
		cls.n_addr = IDX_W'(query.data.n_value);
		cls.k_addr = IDX_W'(query.data.k_value);
		cls.d_addr = IDX_W'(query.data.n_value - query.data.k_value);
		cls.bad    = (query.data.k_value > query.data.n_value) ||
		             (32'(query.data.n_value) > 32'(MAX_N));
		cls.one    = (query.data.k_value == '0) ||
		             (query.data.k_value == query.data.n_value);
	end

	assign query.ready = (cnt_q != (QPTR_W+1)'(QDEPTH)) && !init_busy;
	assign push        = query.valid && query.ready;
	assign head_valid  = (cnt_q != '0);
	assign do_pop      = pop && head_valid;
	assign head        = ent_q[rd_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= cls;
		end
	end

	// Queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);
		end
	end

endmodule

>>> rtl/bmp_back.sv
module bmp_back import bmp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        init_busy,
	input  mm_req_t     init_req,
	output mm_rsp_t     init_rsp,
	input  tbl_wr_t     tbl_wr,
	input  qent_t       head,
	input  logic        head_valid,
	output logic        pop,
	bmp_result_if.source result
);

	logic             adv;
	logic             v_s1;
	logic             bad_s1;
	logic             one_s1;
	logic [VAL_W-1:0] fn_rd;
	logic [VAL_W-1:0] ik_rd;
	logic [VAL_W-1:0] ink_rd;
	logic [VAL_W-1:0] fn_dly_q  [MM_LAT];
	logic             bad_dly_q [2*MM_LAT];
	logic             one_dly_q [2*MM_LAT];
	mm_req_t          mm1_req;
	mm_rsp_t          mm1_rsp;
	mm_req_t          mm2_req;
	mm_rsp_t          mm2_rsp;
	logic             res_valid_q;
	result_t          res_q;
	logic             bad_o;
	logic             one_o;

	// The whole back pipeline moves when the output register can take a result.
	assign adv = !res_valid_q || result.ready;
	assign pop = adv && head_valid && !init_busy;

	// Factorial and two inverse-factorial copies, one read each per request.
	bmp_ram #(.W(VAL_W), .D(DEPTH)) u_fact (
		.clk(clk), .we(tbl_wr.fact_we), .waddr(tbl_wr.addr), .wdata(tbl_wr.data),
		.re(adv), .raddr(head.n_addr), .rdata(fn_rd)
	);
	bmp_ram #(.W(VAL_W), .D(DEPTH)) u_inv_k (
		.clk(clk), .we(tbl_wr.inv_we), .waddr(tbl_wr.addr), .wdata(tbl_wr.data),
		.re(adv), .raddr(head.k_addr), .rdata(ik_rd)
	);
	bmp_ram #(.W(VAL_W), .D(DEPTH)) u_inv_d (
		.clk(clk), .we(tbl_wr.inv_we), .waddr(tbl_wr.addr), .wdata(tbl_wr.data),
		.re(adv), .raddr(head.d_addr), .rdata(ink_rd)
	);

	// Table read stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_s1 <= head.bad;
			one_s1 <= head.one;
		end
	end

	// First multiplier: shared with the start-up fill, then 1/k! * 1/(n-k)!.
	always_comb begin
		if (init_busy) begin
			mm1_req = init_req;
		end else begin
			mm1_req.valid = v_s1;
			mm1_req.a     = ik_rd;
			mm1_req.b     = ink_rd;
		end
	end

	bmp_modmul u_mm1 (
		.clk(clk), .arst_n(arst_n), .en(init_busy || adv), .req(mm1_req), .rsp(mm1_rsp)
	);

	assign init_rsp.valid = mm1_rsp.valid && init_busy;
	assign init_rsp.y     = mm1_rsp.y;

	// Delay lines that keep n! and the case flags beside the multipliers.
	always_ff @(posedge clk) begin
		if (adv) begin
			fn_dly_q[0]  <= fn_rd;
			bad_dly_q[0] <= bad_s1;
			one_dly_q[0] <= one_s1;
			for (int i = 1; i < MM_LAT; i++) begin
				fn_dly_q[i] <= fn_dly_q[i-1];
			end
			for (int i = 1; i < 2*MM_LAT; i++) begin
				bad_dly_q[i] <= bad_dly_q[i-1];
				one_dly_q[i] <= one_dly_q[i-1];
			end
		end
	end

	// Second multiplier: n! times the inverse denominator.
	assign mm2_req.valid = mm1_rsp.valid && !init_busy;
	assign mm2_req.a     = mm1_rsp.y;
	assign mm2_req.b     = fn_dly_q[MM_LAT-1];

	bmp_modmul u_mm2 (
		.clk(clk), .arst_n(arst_n), .en(adv), .req(mm2_req), .rsp(mm2_rsp)
	);

	assign bad_o = bad_dly_q[2*MM_LAT-1];
	assign one_o = one_dly_q[2*MM_LAT-1];

	// Output register with the special cases applied.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= mm2_rsp.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			priority if (bad_o) begin
				res_q.binom_value <= '0;
			end else if (one_o) begin
				res_q.binom_value <= VAL_W'(1);
			end else begin
				res_q.binom_value <= mm2_rsp.y;
			end
			res_q.invalid <= bad_o;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule

>>> tb/binomial_mod_prime_top_tb.sv
module binomial_mod_prime_top_tb import bmp_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM = 1600;
	localparam int PRIME = 1000000007;

	logic clk;
	logic arst_n;

	bmp_query_if query_ch();
	bmp_result_if result_ch();

	binomial_mod_prime_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.query(query_ch.sink),
		.result(result_ch.source)
	);

	// Factorials mod p, built once at time zero.
	int unsigned fact_mod [0:MAX_N];

	query_t  pending_queries[$];
	result_t expected_binoms[$];
	int      error_count;
	bit      hold_off;

	function automatic int unsigned mulmod(int unsigned x, int unsigned y);
		longint unsigned prod;
		prod = longint'(x) * longint'(y);
		return int'(prod % PRIME);
	endfunction

	function automatic int unsigned powmod(int unsigned base, int unsigned e);
		int unsigned acc;
		int unsigned sq;
		acc = 1;
		sq = base % PRIME;
		while (e != 0) begin
			if (e[0])
				acc = mulmod(acc, sq);
			sq = mulmod(sq, sq);
			e = e >> 1;
		end
		return acc;
	endfunction

	// Expected binomial for one request.
	function automatic result_t binom_of(query_t q);
		result_t r;
		int unsigned n;
		int unsigned k;
		int unsigned den;
		n = q.n_value;
		k = q.k_value;
		r.invalid = 1'b0;
		if (k > n || n > MAX_N) begin
			r.binom_value = '0;
			r.invalid = 1'b1;
		end else if (k == 0 || k == n) begin
			r.binom_value = 30'd1;
		end else begin
			den = mulmod(fact_mod[k], fact_mod[n - k]);
			r.binom_value = VAL_W'(mulmod(fact_mod[n], powmod(den, PRIME - 2)));
		end
		return r;
	endfunction

	// Clock.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Reset, asserted at time zero and then released.
	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Request driver with random gaps per request.
	int send_gap;
	initial begin
		query_ch.valid = 1'b0;
		query_ch.data = '0;
		send_gap = 0;
	end
	always @(posedge clk) begin
		if (query_ch.valid && query_ch.ready) begin
			expected_binoms.push_back(binom_of(query_ch.data));
			send_gap = $urandom_range(0, 10);
			if ($urandom_range(0, 3) == 0)
				send_gap = 0;
		end
		if (!(query_ch.valid && !query_ch.ready)) begin
			if (send_gap > 0) begin
				send_gap--;
				query_ch.valid <= 1'b0;
			end else if (arst_n && pending_queries.size() > 0) begin
				query_ch.valid <= 1'b1;
				query_ch.data <= pending_queries.pop_front();
			end else begin
				query_ch.valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off so the pipeline backs up and stalls the input.
	initial begin
		hold_off = 1'b0;
		@(posedge arst_n);
		wait (query_ch.valid && query_ch.ready);
		repeat (200) @(posedge clk);
		hold_off = 1'b1;
		repeat (300) @(posedge clk);
		hold_off = 1'b0;
	end

	// Result monitor with random stalls.
	int recv_gap;
	initial begin
		result_ch.ready = 1'b0;
		recv_gap = 0;
	end
	always @(posedge clk) begin
		if (result_ch.valid && result_ch.ready) begin
			if (expected_binoms.size() == 0) begin
				$error("unexpected result: binom_value %0d invalid %0b",
					result_ch.data.binom_value, result_ch.data.invalid);
				error_count++;
			end else begin
				result_t exp_r;
				exp_r = expected_binoms.pop_front();
				if (result_ch.data.binom_value !== exp_r.binom_value) begin
					$error("binom_value: expected %0d, got %0d",
						exp_r.binom_value, result_ch.data.binom_value);
					error_count++;
				end
				if (result_ch.data.invalid !== exp_r.invalid) begin
					$error("invalid: expected %0b, got %0b",
						exp_r.invalid, result_ch.data.invalid);
					error_count++;
				end
			end
			recv_gap = $urandom_range(0, 10);
			if ($urandom_range(0, 3) == 0)
				recv_gap = 0;
		end
		if (hold_off) begin
			result_ch.ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	function automatic query_t make_query(int unsigned n, int unsigned k);
		query_t q;
		q.n_value = IN_W'(n);
		q.k_value = IN_W'(k);
		return q;
	endfunction

	// Stimulus and end of run.
	initial begin
		int unsigned n;
		int unsigned k;
		error_count = 0;
		fact_mod[0] = 1;
		for (int i = 1; i <= MAX_N; i++)
			fact_mod[i] = mulmod(fact_mod[i - 1], i);

		// Directed: extremes and each special case.
		pending_queries.push_back(make_query(0, 0));
		pending_queries.push_back(make_query(1, 0));
		pending_queries.push_back(make_query(1, 1));
		pending_queries.push_back(make_query(0, 1));
		pending_queries.push_back(make_query(5, 2));
		pending_queries.push_back(make_query(10, 11));
		pending_queries.push_back(make_query(MAX_N, 0));
		pending_queries.push_back(make_query(MAX_N, MAX_N));
		pending_queries.push_back(make_query(MAX_N, 1));
		pending_queries.push_back(make_query(MAX_N, MAX_N - 1));
		pending_queries.push_back(make_query(MAX_N, MAX_N / 2));
		pending_queries.push_back(make_query(MAX_N, 65536));
		pending_queries.push_back(make_query(0, MAX_N));
		pending_queries.push_back(make_query(131070, MAX_N));
		pending_queries.push_back(make_query(2, 1));
		pending_queries.push_back(make_query(100000, 43210));
		pending_queries.push_back(make_query(65535, 32767));

		// Random: mostly valid queries, some with k above n.
		for (int i = 0; i < N_RANDOM; i++) begin
			case ($urandom_range(0, 9))
				0: begin
					n = $urandom_range(0, MAX_N);
					k = $urandom_range(0, MAX_N);
				end
				1: begin
					n = $urandom_range(0, 20);
					k = $urandom_range(0, 20);
				end
				2: begin
					n = $urandom_range(0, MAX_N);
					k = ($urandom_range(0, 1) != 0) ? 0 : n;
				end
				3: begin
					n = $urandom_range(0, 8);
					n = MAX_N - n;
					k = $urandom_range(0, n);
				end
				default: begin
					n = $urandom_range(0, MAX_N);
					k = $urandom_range(0, n);
				end
			endcase
			pending_queries.push_back(make_query(n, k));
		end

		// Table fill after reset takes a long while.
		@(posedge arst_n);

		while (pending_queries.size() != 0 || query_ch.valid)
			@(posedge clk);
		while (expected_binoms.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (error_count == 0 && expected_binoms.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog: fill plus traffic, several times over.
	initial begin
		#60ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
